[rtl/sfd_pkg.sv]
// Shared types, constants and helpers for the stereo feedback delay.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ADDR_W    = 17;
  localparam int DELAY_W   = 17;
  localparam int FB_W      = 15;
  localparam int MIX_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam int SAT_W     = 36;

  localparam logic [FB_W-1:0]  FB_MAX  = FB_W'(31130);
  localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(32768);

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(24000);
  localparam logic [FB_W-1:0]    FB_RST    = FB_W'(9830);
  localparam logic [MIX_W-1:0]   MIX_RST   = MIX_W'(16384);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FB      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIX     = CFG_IDX_W'(3);

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic read;
    logic mult;
    logic emit;
  } sfd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } sfd_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      sat_sample = hi[SAMPLE_W-1:0];
    end else if (x < lo) begin
      sat_sample = lo[SAMPLE_W-1:0];
    end else begin
      sat_sample = x[SAMPLE_W-1:0];
    end
  endfunction

endpackage

[rtl/sfd_ram.sv]
// Simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int ADDR_BITS = 17,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sfd_datapath.sv]
// Datapath: config registers, delay memory, multiply/round/saturate, output register.
`timescale 1ns / 1ps

module sfd_datapath
  import sfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  sfd_cmd_t                   cmd,
  output sfd_status_t                status,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out,
  output logic                       block_end_out
);

  localparam int PFB_W  = 2 * SAMPLE_W;
  localparam int PMIX_W = SAMPLE_W + MIX_W + 2;
  localparam int SUM_W  = PMIX_W + 1;

  logic                enabled;
  logic [DELAY_W-1:0]  delay_samples;
  logic [FB_W-1:0]     feedback;
  logic [MIX_W-1:0]    mix;

  logic signed [SAMPLE_W-1:0] in_l;
  logic signed [SAMPLE_W-1:0] in_r;
  logic                       in_be;

  logic [ADDR_W-1:0] write_pos;
  logic              wrapped;
  logic [ADDR_W-1:0] delay_eff;
  logic [ADDR_W-1:0] read_pos;
  logic              rd_ok;

  logic [2*SAMPLE_W-1:0] ram_rdata;
  logic [2*SAMPLE_W-1:0] ram_wdata;

  logic [FB_W-1:0]  fb_eff;
  logic [MIX_W-1:0] mix_eff;
  logic signed [SAMPLE_W:0]  fb_s;
  logic signed [MIX_W+1:0]   wet_s;
  logic signed [MIX_W+1:0]   dry_s;
  logic signed [SAMPLE_W-1:0] del_l;
  logic signed [SAMPLE_W-1:0] del_r;

  logic signed [PFB_W:0]    p_fb_l, p_fb_r;
  logic signed [PMIX_W-1:0] p_dry_l, p_dry_r, p_wet_l, p_wet_r;

  logic signed [PFB_W:0]   fbr_l, fbr_r;
  logic signed [SUM_W-1:0] mix_l, mix_r;
  logic signed [SAMPLE_W-1:0] st_l, st_r, wet_out_l, wet_out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b1;
      delay_samples <= DELAY_RST;
      feedback      <= FB_RST;
      mix           <= MIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED: enabled       <= cfg_data[0];
        REG_DELAY:   delay_samples <= cfg_data[DELAY_W-1:0];
        REG_FB:      feedback      <= cfg_data[FB_W-1:0];
        REG_MIX:     mix           <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_l  <= left_in;
      in_r  <= right_in;
      in_be <= block_end;
    end
  end

  // delay of zero acts as one, too long acts as depth-1
  always_comb begin
    if (delay_samples == '0) begin
      delay_eff = ADDR_W'(1);
    end else if (64'(delay_samples) > (64'd1 << ADDR_W) - 64'd1) begin
      delay_eff = '1;
    end else begin
      delay_eff = ADDR_W'(delay_samples);
    end
  end

  assign read_pos = write_pos - delay_eff;

  // Stores are written in order from position 0 after a clear, so an entry
  // holds data only if the write pointer has passed it or has wrapped once.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      write_pos <= '0;
      wrapped   <= 1'b0;
    end else if (cmd.emit && enabled) begin
      write_pos <= write_pos + ADDR_W'(1);
      if (write_pos == '1) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_ok <= wrapped || (read_pos < write_pos);
    end
  end

  assign ram_wdata = {st_r, st_l};

  sfd_ram #(
    .ADDR_BITS(ADDR_W),
    .DATA_BITS(2 * SAMPLE_W)
  ) u_store (
    .clk  (clk),
    .we   (cmd.emit && enabled),
    .waddr(write_pos),
    .wdata(ram_wdata),
    .re   (cmd.read),
    .raddr(read_pos),
    .rdata(ram_rdata)
  );

  assign fb_eff  = (feedback > FB_MAX) ? FB_MAX : feedback;
  assign mix_eff = (mix > MIX_ONE) ? MIX_ONE : mix;
  assign fb_s    = $signed({2'b00, fb_eff});
  assign wet_s   = $signed({2'b00, mix_eff});
  assign dry_s   = $signed({2'b00, MIX_ONE}) - wet_s;

  assign del_l = rd_ok ? $signed(ram_rdata[SAMPLE_W-1:0]) : '0;
  assign del_r = rd_ok ? $signed(ram_rdata[2*SAMPLE_W-1:SAMPLE_W]) : '0;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      p_fb_l  <= (PFB_W+1)'(del_l * fb_s);
      p_fb_r  <= (PFB_W+1)'(del_r * fb_s);
      p_dry_l <= PMIX_W'(in_l * dry_s);
      p_dry_r <= PMIX_W'(in_r * dry_s);
      p_wet_l <= PMIX_W'(del_l * wet_s);
      p_wet_r <= PMIX_W'(del_r * wet_s);
    end
  end

  // round half up: floor((p + 2^14) / 2^15)
  assign fbr_l = (p_fb_l + (PFB_W+1)'(16384)) >>> 15;
  assign fbr_r = (p_fb_r + (PFB_W+1)'(16384)) >>> 15;
  assign mix_l = (SUM_W'(p_dry_l) + SUM_W'(p_wet_l) + SUM_W'(16384)) >>> 15;
  assign mix_r = (SUM_W'(p_dry_r) + SUM_W'(p_wet_r) + SUM_W'(16384)) >>> 15;

  assign st_l      = sat_sample(SAT_W'(fbr_l) + SAT_W'(in_l));
  assign st_r      = sat_sample(SAT_W'(fbr_r) + SAT_W'(in_r));
  assign wet_out_l = sat_sample(SAT_W'(mix_l));
  assign wet_out_r = sat_sample(SAT_W'(mix_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out      <= enabled ? wet_out_l : in_l;
      right_out     <= enabled ? wet_out_r : in_r;
      block_end_out <= in_be;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

[rtl/sfd_ctrl.sv]
// Controller: sequences one request through read, multiply and accumulate, or through a clear.
`timescale 1ns / 1ps

module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  input  sfd_status_t status,
  output sfd_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_READ  = 5'b00100,
    S_MULT  = 5'b01000,
    S_ACC   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_op == OP_CLEAR) ? S_CLEAR : S_READ;
        end
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        // hold the finished sample until the output register frees up
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

[rtl/stereo_feedback_delay_line.sv]
// Top level of the stereo feedback delay echo.
// A sample request passes in turn through memory read, multiply and accumulate, and
// its result is registered for the output; no new request is taken until it is done.
// A clear request goes through a clear step. A full output register stalls the accumulate step.
// Reset: synchronous; registers return to defaults, stores read as zero at once.
`timescale 1ns / 1ps

module stereo_feedback_delay_line
  import sfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*SAMPLE_W-1:0] s_axis_tdata,  // left_in [15:0], right_in [31:16]
  input  logic                  s_axis_tuser,  // op
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*SAMPLE_W-1:0] m_axis_tdata,  // left_out [15:0], right_out [31:16]
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  sfd_cmd_t    cmd;
  sfd_status_t status;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  sfd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_op   (s_axis_tuser),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  sfd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_in      ($signed(s_axis_tdata[SAMPLE_W-1:0])),
    .right_in     ($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
    .block_end    (s_axis_tlast),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .left_out     (left_out),
    .right_out    (right_out),
    .block_end_out(m_axis_tlast)
  );

  assign m_axis_tdata = {right_out, left_out};

endmodule

[rtl/sfd_checker.sv]
// Port-level checks for the stereo feedback delay, bound to the top level.
`timescale 1ns / 1ps

module sfd_checker
  import sfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [2*SAMPLE_W-1:0] m_axis_tdata
);

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output valid or input blocked after reset");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  // a clear request does not raise the result valid right after it is taken
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR) |=> !$rose(m_axis_tvalid))
    else $error("clear request produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind stereo_feedback_delay_line sfd_checker u_sfd_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
